// File: src/sac_pkg.sv
// Shared types and constants of the set-associative write-back cache.
package sac_pkg;

  localparam int CFGW      = 17;
  localparam int ADDRW     = 31;
  localparam int CNTW      = 32;
  localparam int CFG_IDXW  = 2;
  localparam int DIV_CNTW  = 5;

  localparam logic [CFG_IDXW-1:0] CFG_CACHE_BYTES = 2'd0;
  localparam logic [CFG_IDXW-1:0] CFG_BLOCK_BYTES = 2'd1;
  localparam logic [CFG_IDXW-1:0] CFG_WAYS        = 2'd2;

  localparam logic [DIV_CNTW-1:0] DIV_STEPS = 5'd31;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [ADDRW-1:0] addr;
  } in_t;

  typedef struct packed {
    logic            hit;
    logic            dirty_writeback;
    logic [1:0]      filled_way;
    logic [CNTW-1:0] miss_total;
    logic [CNTW-1:0] writeback_total;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [ADDRW-1:0] tag;
    logic [CNTW-1:0]  stamp;
  } line_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic step;
    logic fin1;
    logic fin2;
    logic fin3;
    logic ev;
    logic wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ev_done;
  } sts_t;

endpackage

// File: src/sac_ctrl.sv
// Controller state machine sequencing the clearing pass, divisions, the way walk and the line update.
module sac_ctrl
  import sac_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DIV1  = 8'b0000_0100,
    S_DIV2  = 8'b0000_1000,
    S_DIV3  = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_EV    = 8'b0100_0000,
    S_WR    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [DIV_CNTW-1:0] cnt_r, cnt_nxt;
  logic last_step;

  assign last_step = (cnt_r == DIV_STEPS);
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DIV1;
        end
      end
      S_DIV1, S_DIV2, S_DIV3: begin
        if (last_step) begin
          cnt_nxt  = '0;
          cmd.fin1 = (state_r == S_DIV1);
          cmd.fin2 = (state_r == S_DIV2);
          cmd.fin3 = (state_r == S_DIV3);
          state_nxt = (state_r == S_DIV1) ? S_DIV2 :
                      (state_r == S_DIV2) ? S_DIV3 : S_RD;
        end else begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        cmd.ev    = 1'b1;
        state_nxt = sts.ev_done ? S_WR : S_RD;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: src/sac_dp.sv
// Datapath: configuration, serial divider, line store, way walk and counters.
module sac_dp
  import sac_pkg::*;
#(
  parameter int MAX_SETS = 512,
  parameter int MAX_WAYS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_IDXW-1:0] cfg_idx,
  input  logic [CFGW-1:0]     cfg_wdata,
  input  in_t                 in_data,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_valid,
  output out_t                out_data
);

  localparam int WAYW  = $clog2(MAX_WAYS + 1);
  localparam int WIW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SETW  = $clog2(MAX_SETS + 1);
  localparam int SIW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int LINES = MAX_SETS * MAX_WAYS;
  localparam int IW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int DVW   = CFGW + WAYW;

  logic [CFGW-1:0] cache_r, blk_r;
  logic [2:0]      ways_r;
  logic [CFGW-1:0] blk_w;
  logic [WAYW-1:0] nway_w;

  in_t              in_r;
  logic [ADDRW-1:0] quo_r;
  logic [DVW-1:0]   rem_r, dvs_r;
  logic [DVW:0]     rem_sh, diff;
  logic             ge;
  logic [SETW-1:0]  sets_r;
  logic [ADDRW-1:0] tag_r;
  logic [IW-1:0]    base_r, clr_idx_r, ra, wa;

  logic [WIW-1:0]  way_r, chosen_r, vict_r;
  logic            hit_r, free_r, hdirty_r, vdirty_r;
  logic [CNTW-1:0] vstamp_r;
  logic [CNTW-1:0] clock_r, miss_r, wbcnt_r;

  line_t mem [LINES];
  line_t rd_q, wd;
  logic  mem_we, hit_now, miss_w, wb_w;
  logic [WIW-1:0] fin_way;
  logic [31:0] fin32;

  assign blk_w  = (blk_r == '0) ? CFGW'(1) : blk_r;
  assign nway_w = (ways_r == '0) ? WAYW'(1) :
                  (32'(ways_r) > 32'(MAX_WAYS)) ? WAYW'(MAX_WAYS) : WAYW'(ways_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_r <= CFGW'(1024);
      blk_r   <= CFGW'(100);
      ways_r  <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CACHE_BYTES: cache_r <= cfg_wdata;
        CFG_BLOCK_BYTES: blk_r   <= cfg_wdata;
        CFG_WAYS:        ways_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign rem_sh = {rem_r, quo_r[ADDRW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r  <= in_data;
      quo_r <= ADDRW'(cache_r);
      rem_r <= '0;
      dvs_r <= DVW'(blk_w) * DVW'(nway_w);
    end else if (cmd.step) begin
      rem_r <= ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
      quo_r <= {quo_r[ADDRW-2:0], ge};
    end else if (cmd.fin1) begin
      if (quo_r == '0)                      sets_r <= SETW'(1);
      else if (quo_r > ADDRW'(MAX_SETS))    sets_r <= SETW'(MAX_SETS);
      else                                  sets_r <= SETW'(quo_r);
      quo_r <= in_r.addr;
      rem_r <= '0;
      dvs_r <= DVW'(blk_w);
    end else if (cmd.fin2) begin
      rem_r <= '0;
      dvs_r <= DVW'(sets_r);
    end else if (cmd.fin3) begin
      tag_r  <= quo_r;
      base_r <= IW'(32'(rem_r[SIW-1:0]) * 32'(nway_w));
    end
  end

  // way walk
  assign hit_now = rd_q.valid && (rd_q.tag == tag_r);
  assign sts.ev_done = hit_now || (32'(way_r) == 32'(nway_w) - 32'd1);
  assign sts.clr_last = (32'(clr_idx_r) == LINES - 1);

  always_ff @(posedge clk) begin
    if (cmd.fin3) begin
      way_r    <= '0;
      chosen_r <= '0;
      vict_r   <= '0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      hdirty_r <= 1'b0;
      vdirty_r <= 1'b0;
      vstamp_r <= '0;
    end else if (cmd.ev) begin
      way_r <= way_r + 1'b1;
      if (hit_now) begin
        hit_r    <= 1'b1;
        chosen_r <= way_r;
        hdirty_r <= rd_q.dirty;
      end else if (!rd_q.valid && !free_r) begin
        free_r   <= 1'b1;
        chosen_r <= way_r;
      end
      if (way_r == '0 || rd_q.stamp < vstamp_r) begin
        vict_r   <= way_r;
        vstamp_r <= rd_q.stamp;
        vdirty_r <= rd_q.dirty;
      end
    end
  end

  assign miss_w  = !hit_r;
  assign wb_w    = !hit_r && !free_r && vdirty_r;
  assign fin_way = (hit_r || free_r) ? chosen_r : vict_r;
  assign fin32   = 32'(fin_way);

  assign ra = base_r + IW'(way_r);
  assign wa = cmd.clr ? clr_idx_r : base_r + IW'(fin_way);
  assign mem_we = cmd.clr || cmd.wr;

  always_comb begin
    wd = '0;
    if (!cmd.clr) begin
      wd.valid = 1'b1;
      wd.dirty = (in_r.cmd == CMD_WRITE) || (hit_r && hdirty_r);
      wd.tag   = tag_r;
      wd.stamp = clock_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      clock_r   <= '0;
      miss_r    <= '0;
      wbcnt_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.wr;
      if (cmd.clr) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.wr) begin
        clock_r <= clock_r + 1'b1;
        miss_r  <= miss_r + CNTW'(miss_w);
        wbcnt_r <= wbcnt_r + CNTW'(wb_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      out_data.hit             <= hit_r;
      out_data.dirty_writeback <= wb_w;
      out_data.filled_way      <= fin32[1:0];
      out_data.miss_total      <= miss_r + CNTW'(miss_w);
      out_data.writeback_total <= wbcnt_r + CNTW'(wb_w);
    end
  end

endmodule

// File: src/set_assoc_write_back_cache_unit.sv
// Three 31-step serial divisions compute the set count, the block number and the set/tag.
// One access at a time: busy stays high until the result beat, and no new access is taken meanwhile.
// Reset: synchronous; a clearing pass over all MAX_SETS*MAX_WAYS lines (2048 by default)
// then runs with busy high; configuration writes are taken meanwhile.
// The receiver cannot stall: each result is shown for exactly one cycle.
module set_assoc_write_back_cache_unit
  import sac_pkg::*;
#(
  parameter int MAX_SETS = 512,
  parameter int MAX_WAYS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_IDXW-1:0] cfg_idx,
  input  logic [CFGW-1:0]     cfg_wdata,
  input  logic                start,
  input  in_t                 in_data,
  output logic                busy,
  output logic                out_valid,
  output out_t                out_data
);

  cmd_t cmd;
  sts_t sts;

  sac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  sac_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted access did not raise busy");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat lasted more than one cycle");

  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> !out_data.dirty_writeback)
    else $error("writeback reported on a hit");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the set-associative write-back cache unit.
`timescale 1ns / 1ps

module testbench;
  import sac_pkg::*;

  localparam int NSETS = 512;
  localparam int NWAYS = 4;
  localparam int NLINES = NSETS * NWAYS;

  class cache_scoreboard;
    logic [CFGW-1:0] cache_bytes, block_bytes;
    logic [2:0] ways;
    line_t lines[NLINES];
    logic [CNTW-1:0] clock_ctr, misses, writebacks;
    out_t pending[$];
    int errors;

    function void clear();
      cache_bytes = CFGW'(1024); block_bytes = CFGW'(100); ways = 3'd1;
      foreach (lines[i]) lines[i] = '0;
      clock_ctr = '0; misses = '0; writebacks = '0;
      pending.delete(); errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDXW-1:0] idx, logic [CFGW-1:0] val);
      case (idx)
        CFG_CACHE_BYTES: cache_bytes = val;
        CFG_BLOCK_BYTES: block_bytes = val;
        CFG_WAYS: ways = val[2:0];
        default: ;
      endcase
    endfunction

    function void note_access(in_t a);
      longint unsigned blk, nway, nsets, blocknum, setn, tag, base;
      int chosen;
      bit hit, free_found, wb;
      out_t r;
      blk = (block_bytes == 0) ? 1 : block_bytes;
      nway = (ways == 0) ? 1 : ways;
      if (nway > NWAYS) nway = NWAYS;
      nsets = cache_bytes / (blk * nway);
      if (nsets == 0) nsets = 1;
      if (nsets > NSETS) nsets = NSETS;
      blocknum = a.addr / blk;
      setn = blocknum % nsets;
      tag = blocknum / nsets;
      base = setn * nway;
      clock_ctr++;
      chosen = 0; hit = 0; free_found = 0; wb = 0;
      for (int w = 0; w < nway; w++) begin
        if (lines[base+w].valid && lines[base+w].tag == tag[ADDRW-1:0]) begin
          hit = 1; chosen = w; break;
        end
        if (!lines[base+w].valid && !free_found) begin
          free_found = 1; chosen = w;
        end
      end
      if (hit) begin
        lines[base+chosen].stamp = clock_ctr;
        if (a.cmd == CMD_WRITE) lines[base+chosen].dirty = 1;
      end else begin
        misses++;
        if (!free_found) begin
          chosen = 0;
          for (int w = 1; w < nway; w++)
            if (lines[base+w].stamp < lines[base+chosen].stamp) chosen = w;
          if (lines[base+chosen].dirty) begin
            wb = 1; writebacks++;
          end
        end
        lines[base+chosen].valid = 1;
        lines[base+chosen].tag = tag[ADDRW-1:0];
        lines[base+chosen].stamp = clock_ctr;
        lines[base+chosen].dirty = (a.cmd == CMD_WRITE);
      end
      r.hit = hit; r.dirty_writeback = wb; r.filled_way = chosen[1:0];
      r.miss_total = misses; r.writeback_total = writebacks;
      pending.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %p", $realtime, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit) begin
        $display("%0t: hit exp %0d got %0d", $realtime, exp.hit, got.hit); errors++;
      end
      if (got.dirty_writeback !== exp.dirty_writeback) begin
        $display("%0t: dirty_writeback exp %0d got %0d", $realtime,
                 exp.dirty_writeback, got.dirty_writeback); errors++;
      end
      if (got.filled_way !== exp.filled_way) begin
        $display("%0t: filled_way exp %0d got %0d", $realtime,
                 exp.filled_way, got.filled_way); errors++;
      end
      if (got.miss_total !== exp.miss_total) begin
        $display("%0t: miss_total exp %0d got %0d", $realtime,
                 exp.miss_total, got.miss_total); errors++;
      end
      if (got.writeback_total !== exp.writeback_total) begin
        $display("%0t: writeback_total exp %0d got %0d", $realtime,
                 exp.writeback_total, got.writeback_total); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDXW-1:0] cfg_idx = '0;
  logic [CFGW-1:0] cfg_wdata = '0;
  logic start = 0;
  in_t in_data = '0;
  logic busy, out_valid;
  out_t out_data;

  cache_scoreboard sb;
  int idle_pct;
  logic [ADDRW-1:0] hot_base;

  always #6 clk = ~clk;

  set_assoc_write_back_cache_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .start(start), .in_data(in_data),
    .busy(busy), .out_valid(out_valid), .out_data(out_data)
  );

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_data);

  task automatic write_reg(logic [CFG_IDXW-1:0] idx, logic [CFGW-1:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_geometry(int cb, int bb, int w);
    write_reg(CFG_CACHE_BYTES, cb[CFGW-1:0]);
    write_reg(CFG_BLOCK_BYTES, bb[CFGW-1:0]);
    write_reg(CFG_WAYS, w[CFGW-1:0]);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic send_access(bit cmd, logic [ADDRW-1:0] addr);
    in_t a;
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    a.cmd = cmd; a.addr = addr;
    start <= 1; in_data <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_access(a);
    start <= 0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    bit cmd;
    logic [ADDRW-1:0] addr;
    hot_base = ADDRW'($urandom);
    for (int i = 0; i < count; i++) begin
      cmd = 1'($urandom_range(1));
      case ($urandom_range(9))
        0, 1: addr = ADDRW'($urandom);
        2: addr = ($urandom_range(1) != 0) ?
                  {ADDRW{1'b1}} - ADDRW'($urandom_range(300)) :
                  ADDRW'($urandom_range(300));
        default: addr = hot_base + ADDRW'($urandom_range(8191));
      endcase
      send_access(cmd, addr);
    end
  endtask

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear();
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: reset geometry, then edge cases
    send_access(0, '0);
    send_access(1, '0);
    send_access(0, {ADDRW{1'b1}});
    send_access(1, 31'd1024);
    send_access(0, '0);
    drain();
    set_geometry(0, 0, 0);
    send_access(1, 31'd5);
    send_access(0, {ADDRW{1'b1}});
    drain();
    set_geometry(65536, 1, 7);
    send_access(1, 31'd0);
    send_access(1, 31'd512);
    send_access(1, 31'd1024);
    send_access(1, 31'd1536);
    send_access(0, 31'd2048);
    send_access(0, 31'd2560);
    send_access(0, 31'd0);
    drain();
    set_geometry(65536, 65536, 4);
    send_access(1, 31'h7FFF_FFFF);
    send_access(0, 31'h5555_5555);
    send_access(1, 31'h2AAA_AAAA);
    drain();
    set_geometry(96, 8, 3);
    for (int i = 0; i < 8; i++) send_access(i[0], ADDRW'(i * 32));
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 61;
        2: idle_pct = 7;
        default: idle_pct = $urandom_range(30);
      endcase
      case ($urandom_range(5))
        0: set_geometry(1024, 100, 1);
        1: set_geometry(65536, 1, 4);
        2: set_geometry($urandom_range(1, 65536), $urandom_range(1, 64), $urandom_range(0, 7));
        3: set_geometry($urandom_range(1, 4096), $urandom_range(1, 200), $urandom_range(1, 4));
        4: set_geometry(4096, 16, 4);
        default: set_geometry($urandom_range(1, 65536), $urandom_range(1, 65536),
                              $urandom_range(1, 4));
      endcase
      random_phase(105);
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
